// ----- hdl/edd_pkg.sv -----
// Shared constants and types for the error-diffusion dither block.
`timescale 1ns / 1ps

package edd_pkg;

  localparam int MaxWidth       = 1024;
  localparam int AddrW          = $clog2(MaxWidth);
  localparam int CfgW           = 11;
  localparam int LineWidthReset = 640;
  localparam int LevelW         = 8;
  localparam int ErrW           = 9;
  localparam int CarryW         = 7;
  localparam int QW             = 4;
  localparam int SumW           = 11;

  // Pixel word held between accept and the diffusion stage.
  typedef struct packed {
    logic [LevelW-1:0] level;
    logic              frame_start;
    logic              first_row;
    logic              last;
    logic [AddrW-1:0]  col;
  } s1_t;

  // Error-row writes issued by the diffusion stage.
  typedef struct packed {
    logic                   adv;
    logic                   near_en;
    logic [AddrW-1:0]       near_addr;
    logic signed [ErrW-1:0] near_data;
    logic                   tail_en;
    logic [AddrW-1:0]       tail_addr;
    logic signed [ErrW-1:0] tail_data;
  } dif_wr_t;

endpackage

// ----- hdl/edd_ifs.sv -----
// Valid/ready channel interfaces for pixel input and dithered output words.
`timescale 1ns / 1ps

interface edd_pix_in_if;
  logic                        valid;
  logic                        ready;
  logic [edd_pkg::LevelW-1:0]  pixel_level;
  logic                        frame_start;

  modport source (output valid, output pixel_level, output frame_start, input ready);
  modport sink   (input valid, input pixel_level, input frame_start, output ready);
endinterface

interface edd_pix_out_if;
  logic valid;
  logic ready;
  logic pixel_on;
  logic row_end;

  modport source (output valid, output pixel_on, output row_end, input ready);
  modport sink   (input valid, input pixel_on, input row_end, output ready);
endinterface

// ----- hdl/edd_col_track.sv -----
// Input stage: width register, column counter, first-row flag and input word register.
`timescale 1ns / 1ps

module edd_col_track (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [edd_pkg::CfgW-1:0]     cfg_wr_data,
  edd_pix_in_if.sink                   pix_in,
  input  logic                         clr_busy,
  input  logic                         adv,
  output edd_pkg::s1_t                 s1,
  output logic                         s1_valid,
  output logic                         rd_en,
  output logic [edd_pkg::AddrW-1:0]    rd_addr
);
  import edd_pkg::*;

  logic [AddrW-1:0] last_col;
  logic [AddrW-1:0] col_count;
  logic             first_row;
  logic [AddrW-1:0] x;
  logic             last;
  logic             flag_eff;
  logic             acc;

  assign pix_in.ready = !clr_busy && (!s1_valid || adv);
  assign acc          = pix_in.valid && pix_in.ready;
  assign x            = pix_in.frame_start ? '0 : col_count;
  assign last         = (x >= last_col);
  assign flag_eff     = pix_in.frame_start || first_row;
  assign rd_en        = acc;
  assign rd_addr      = x;

  // Last column, clamped to the legal width range.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_col <= AddrW'(LineWidthReset - 1);
    end else if (cfg_wr_en) begin
      if (cfg_wr_data < CfgW'(2)) begin
        last_col <= AddrW'(1);
      end else if (int'(cfg_wr_data) > MaxWidth) begin
        last_col <= AddrW'(MaxWidth - 1);
      end else begin
        last_col <= AddrW'(cfg_wr_data - CfgW'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      first_row <= 1'b1;
      s1_valid  <= 1'b0;
    end else begin
      if (acc) begin
        col_count <= last ? '0 : x + AddrW'(1);
        first_row <= last ? 1'b0 : flag_eff;
        s1_valid  <= 1'b1;
      end else if (adv) begin
        s1_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1.level       <= pix_in.pixel_level;
      s1.frame_start <= pix_in.frame_start;
      s1.first_row   <= flag_eff;
      s1.last        <= last;
      s1.col         <= x;
    end
  end

  a_no_acc_clr: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> !pix_in.ready)
    else $error("word accepted during error row clear");
  a_row_wrap: assert property (@(posedge clk) disable iff (rst)
    acc && last |=> col_count == '0 && !first_row)
    else $error("column counter did not wrap at row end");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !adv |=> s1_valid && $stable(s1))
    else $error("input word lost while stalled");

endmodule

// ----- hdl/edd_err_store.sv -----
// Error row memory with clear on reset, deferred row-end write and read forwarding.
`timescale 1ns / 1ps

module edd_err_store (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              rd_en,
  input  logic [edd_pkg::AddrW-1:0]         rd_addr,
  input  edd_pkg::dif_wr_t                  wr,
  output logic                              clr_busy,
  output logic signed [edd_pkg::ErrW-1:0]   incoming
);
  import edd_pkg::*;

  logic signed [ErrW-1:0] mem [MaxWidth];
  logic signed [ErrW-1:0] mem_q;
  logic [AddrW-1:0]       clr_addr;
  logic                   pend_valid;
  logic [AddrW-1:0]       pend_addr;
  logic signed [ErrW-1:0] pend_data;
  logic                   drain;
  logic                   wp_en;
  logic [AddrW-1:0]       wp_addr;
  logic signed [ErrW-1:0] wp_data;
  logic                   fwd_hit;
  logic signed [ErrW-1:0] fwd_data;

  assign drain = pend_valid && !wr.near_en;

  always_comb begin
    if (clr_busy) begin
      wp_en   = 1'b1;
      wp_addr = clr_addr;
      wp_data = '0;
    end else if (wr.near_en) begin
      wp_en   = 1'b1;
      wp_addr = wr.near_addr;
      wp_data = wr.near_data;
    end else begin
      wp_en   = pend_valid;
      wp_addr = pend_addr;
      wp_data = pend_data;
    end
  end

  always_ff @(posedge clk) begin
    if (wp_en) begin
      mem[wp_addr] <= wp_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy   <= 1'b1;
      clr_addr   <= '0;
      pend_valid <= 1'b0;
    end else begin
      if (clr_busy) begin
        clr_addr <= clr_addr + AddrW'(1);
        if (clr_addr == AddrW'(MaxWidth - 1)) begin
          clr_busy <= 1'b0;
        end
      end
      if (wr.tail_en) begin
        pend_valid <= 1'b1;
      end else if (drain) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr.tail_en) begin
      pend_addr <= wr.tail_addr;
      pend_data <= wr.tail_data;
    end
  end

  // Catch writes that land on the same edge as the read.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (rd_en) begin
      if (wr.tail_en && wr.tail_addr == rd_addr) begin
        fwd_hit  <= 1'b1;
        fwd_data <= wr.tail_data;
      end else if (wp_en && wp_addr == rd_addr) begin
        fwd_hit  <= 1'b1;
        fwd_data <= wp_data;
      end else if (pend_valid && !drain && pend_addr == rd_addr) begin
        fwd_hit  <= 1'b1;
        fwd_data <= pend_data;
      end else begin
        fwd_hit  <= 1'b0;
      end
    end
  end

  assign incoming = fwd_hit ? fwd_data : mem_q;

  a_tail_pair: assert property (@(posedge clk) disable iff (rst)
    wr.tail_en |-> wr.near_en)
    else $error("row-end write without its neighbor write");
  a_pend_free: assert property (@(posedge clk) disable iff (rst)
    wr.tail_en |-> !pend_valid)
    else $error("deferred write overwritten before drain");
  a_clr_quiet: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> !rd_en && !wr.near_en && !wr.tail_en)
    else $error("traffic during error row clear");

endmodule

// ----- hdl/edd_diffuse.sv -----
// Diffusion stage: threshold, error split, carries and the output word register.
`timescale 1ns / 1ps

module edd_diffuse (
  input  logic                              clk,
  input  logic                              rst,
  input  edd_pkg::s1_t                      s1,
  input  logic                              s1_valid,
  input  logic signed [edd_pkg::ErrW-1:0]   incoming,
  edd_pix_out_if.source                     pix_out,
  output edd_pkg::dif_wr_t                  wr
);
  import edd_pkg::*;

  logic signed [CarryW-1:0] rc;
  logic signed [ErrW-1:0]   bp0;
  logic signed [ErrW-1:0]   bp1;
  logic signed [CarryW-1:0] rc_e;
  logic signed [ErrW-1:0]   bp0_e;
  logic signed [ErrW-1:0]   bp1_e;
  logic signed [ErrW-1:0]   inc;
  logic signed [SumW-1:0]   sum;
  logic                     on;
  logic signed [SumW-1:0]   err;
  logic signed [SumW-1:0]   qfull;
  logic signed [QW-1:0]     q;
  logic signed [ErrW-1:0]   q9;
  logic signed [ErrW-1:0]   near;
  logic signed [ErrW-1:0]   cur;
  logic signed [ErrW-1:0]   q7;
  logic                     adv;

  assign adv   = s1_valid && (!pix_out.valid || pix_out.ready);

  assign rc_e  = s1.frame_start ? '0 : rc;
  assign bp0_e = s1.frame_start ? '0 : bp0;
  assign bp1_e = s1.frame_start ? '0 : bp1;
  assign inc   = s1.first_row ? '0 : incoming;

  assign sum   = $signed({{(SumW-LevelW){1'b0}}, s1.level}) + SumW'(rc_e) + SumW'(inc);
  assign on    = (sum >= SumW'(128));
  assign err   = on ? sum - SumW'(255) : sum;
  // Divide by 16, rounding toward zero.
  assign qfull = (err + (err < 0 ? SumW'(15) : SumW'(0))) >>> 4;
  assign q     = QW'(qfull);
  assign q9    = ErrW'(q);
  assign near  = bp0_e + (q9 <<< 1) + q9;
  assign cur   = bp1_e + (q9 <<< 2) + q9;
  assign q7    = (q9 <<< 3) - q9;

  assign wr.adv       = adv;
  assign wr.near_en   = adv && (s1.col != '0);
  assign wr.near_addr = s1.col - AddrW'(1);
  assign wr.near_data = near;
  assign wr.tail_en   = adv && s1.last;
  assign wr.tail_addr = s1.col;
  assign wr.tail_data = cur;

  always_ff @(posedge clk) begin
    if (rst) begin
      rc  <= '0;
      bp0 <= '0;
      bp1 <= '0;
    end else if (adv) begin
      if (s1.last) begin
        rc  <= '0;
        bp0 <= '0;
        bp1 <= '0;
      end else begin
        rc  <= CarryW'(q7);
        bp0 <= cur;
        bp1 <= q9;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_out.valid <= 1'b0;
    end else if (adv) begin
      pix_out.valid <= 1'b1;
    end else if (pix_out.ready) begin
      pix_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pix_out.pixel_on <= on;
      pix_out.row_end  <= s1.last;
    end
  end

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    adv |=> pix_out.valid)
    else $error("output word not loaded");
  a_row_clear: assert property (@(posedge clk) disable iff (rst)
    adv && s1.last |=> rc == '0 && bp0 == '0 && bp1 == '0)
    else $error("carries not cleared at row end");
  a_last_col: assert property (@(posedge clk) disable iff (rst)
    wr.tail_en |-> s1.col != '0)
    else $error("row end at column zero");

endmodule

// ----- hdl/error_diffusion_dither_top.sv -----
// Top level of the error-diffusion (Floyd-Steinberg) dither block.
//
// pix_in carries one 8-bit grey pixel per word in raster order; frame_start
// marks the first pixel of a frame. pix_out returns one word per pixel:
// pixel_on (1 = full white) and row_end on the last pixel of each row.
// cfg_wr_en/cfg_wr_data set line_width (pixels per row, clamped to 2..1024,
// 640 after reset); write it only while no pixel is in flight.
// An accepted pixel goes through the input register, then the output register.
// Throughput: one pixel per clock unless the receiver stalls, set by the error
// row memory with one read and one write port (one read at accept, one write per
// cycle; the row-end second write is deferred into the next cycle's free slot).
// Reset (rst, synchronous): clears control state, then sweeps the 1024-entry
// error row to zero with pix_in.ready low.
// When the receiver stalls, the output register holds its word and one more
// pixel waits in the input register; after that pix_in.ready drops.
`timescale 1ns / 1ps

module error_diffusion_dither_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [edd_pkg::CfgW-1:0]   cfg_wr_data,
  edd_pix_in_if.sink                 pix_in,
  edd_pix_out_if.source              pix_out
);
  import edd_pkg::*;

  s1_t                    s1;
  logic                   s1_valid;
  logic                   rd_en;
  logic [AddrW-1:0]       rd_addr;
  logic                   clr_busy;
  logic signed [ErrW-1:0] incoming;
  dif_wr_t                wr;

  edd_col_track u_col_track (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .pix_in      (pix_in),
    .clr_busy    (clr_busy),
    .adv         (wr.adv),
    .s1          (s1),
    .s1_valid    (s1_valid),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr)
  );

  edd_err_store u_err_store (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .wr       (wr),
    .clr_busy (clr_busy),
    .incoming (incoming)
  );

  edd_diffuse u_diffuse (
    .clk      (clk),
    .rst      (rst),
    .s1       (s1),
    .s1_valid (s1_valid),
    .incoming (incoming),
    .pix_out  (pix_out),
    .wr       (wr)
  );

endmodule
